// ----- src/scpdt_pkg.sv -----
// shared widths, types and helpers for the sub-cell pair distance test
`timescale 1ns / 1ps
package scpdt_pkg;

    localparam int AXES        = 3;
    localparam int RES_W       = 5;
    localparam int OFF_W       = 4;
    localparam int SUB_W       = 5;
    localparam int CODE_W      = AXES * SUB_W;
    localparam int PROD_W      = 10;   // res_a*res_b and sub-cell bounds in scaled units
    localparam int POS_W       = 14;   // neighbour bounds including the cell offset
    localparam int GAP_W       = 14;
    localparam int CS_W        = 16;
    localparam int MD_W        = 20;
    localparam int DIST_W      = 30;   // cell edge*gap and max_distance*res_a*res_b
    localparam int SQ_W        = 2 * DIST_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int NUM_STAGES  = 7;

    localparam int MAX_RES     = 31;
    localparam int MAX_LAYERS  = 15;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 32;

    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    // register index, taken from paddr[2]
    localparam logic REG_CELL_EDGE = 1'b0;
    localparam logic REG_MAX_DIST  = 1'b1;

    localparam logic [CS_W-1:0] CELL_EDGE_RST = CS_W'(256);
    localparam logic [MD_W-1:0] MAX_DIST_RST  = MD_W'(256);

    typedef logic [AXES-1:0][SUB_W-1:0]  t_sub_vec;   // x in the lowest bits
    typedef logic [AXES-1:0][OFF_W-1:0]  t_off_vec;
    typedef logic [AXES-1:0][PROD_W-1:0] t_prod_vec;
    typedef logic [AXES-1:0][POS_W-1:0]  t_pos_vec;
    typedef logic [AXES-1:0][GAP_W-1:0]  t_gap_vec;
    typedef logic [AXES-1:0][DIST_W-1:0] t_dist_vec;
    typedef logic [AXES-1:0][SQ_W-1:0]   t_sq_vec;

    typedef struct packed {
        logic [CODE_W-1:0] code_b;
        logic [CODE_W-1:0] code_a;
    } t_codes;

    function automatic logic [RES_W-1:0] clamp_res(input logic [RES_W-1:0] r);
        logic [RES_W-1:0] v;
        if (r == '0) begin
            v = RES_W'(1);
        end else if (r > RES_W'(MAX_RES)) begin
            v = RES_W'(MAX_RES);
        end else begin
            v = r;
        end
        return v;
    endfunction

    function automatic logic [OFF_W-1:0] clamp_off(input logic [OFF_W-1:0] o);
        logic [OFF_W-1:0] v;
        v = (o > OFF_W'(MAX_LAYERS)) ? OFF_W'(MAX_LAYERS) : o;
        return v;
    endfunction

endpackage

// ----- src/scpdt_regs.sv -----
// apb configuration registers: cell size and cutoff distance
`timescale 1ns / 1ps
module scpdt_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [scpdt_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [scpdt_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [scpdt_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic [scpdt_pkg::CS_W-1:0]         o_cell_edge,
    output logic [scpdt_pkg::MD_W-1:0]         o_max_distance
);
    import scpdt_pkg::*;

    logic [CS_W-1:0] r_cell_edge;
    logic [MD_W-1:0] r_max_distance;
    logic            w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_edge    <= CELL_EDGE_RST;
            r_max_distance <= MAX_DIST_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_CELL_EDGE: r_cell_edge    <= pwdata[CS_W-1:0];
                REG_MAX_DIST:  r_max_distance <= pwdata[MD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_CELL_EDGE: prdata = {{(APB_DATA_W-CS_W){1'b0}}, r_cell_edge};
            REG_MAX_DIST:  prdata = {{(APB_DATA_W-MD_W){1'b0}}, r_max_distance};
            default:       prdata = '0;
        endcase
    end

    assign o_cell_edge    = r_cell_edge;
    assign o_max_distance = r_max_distance;

endmodule

// ----- src/scpdt_ctrl.sv -----
// pipeline valid bits and per-stage load enables with bubble collapsing
`timescale 1ns / 1ps
module scpdt_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_valid,
    input  logic                              i_m_ready,
    output logic                              o_s_ready,
    output logic                              o_m_valid,
    output logic [scpdt_pkg::NUM_STAGES-1:0]  o_load
);
    import scpdt_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] n_valid;
    logic [NUM_STAGES-1:0] w_load;
    logic                  w_in_acc;
    logic                  w_out_acc;

    // a stage loads when it is empty or the next one moves on
    always_comb begin
        w_load[NUM_STAGES-1] = ~r_valid[NUM_STAGES-1] | i_m_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_load[k] = ~r_valid[k] | w_load[k+1];
        end
    end

    always_comb begin
        n_valid[0] = w_load[0] ? i_s_valid : r_valid[0];
        for (int k = 1; k < NUM_STAGES; k++) begin
            n_valid[k] = w_load[k] ? r_valid[k-1] : r_valid[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_load    = w_load;
    assign o_s_ready = w_load[0];
    assign o_m_valid = r_valid[NUM_STAGES-1];
    assign w_in_acc  = i_s_valid & w_load[0];
    assign w_out_acc = r_valid[NUM_STAGES-1] & i_m_ready;

    // input only backs up when every stage holds a transaction
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_ready |-> (&r_valid) && !i_m_ready)
        else $error("input stalled with a bubble in the pipeline");

    // transactions are neither lost nor duplicated
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> $countones(r_valid) == $countones($past(r_valid))
            + ($past(w_in_acc) ? 1 : 0) - ($past(w_out_acc) ? 1 : 0))
        else $error("pipeline occupancy mismatch");

    // a stalled stage keeps its transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[NUM_STAGES-2] && !w_load[NUM_STAGES-1] |=> r_valid[NUM_STAGES-2])
        else $error("stalled transaction dropped");

endmodule

// ----- src/scpdt_gap.sv -----
// stages 1-3: scaled box bounds, cutoff scaling and per-axis gaps
`timescale 1ns / 1ps
module scpdt_gap (
    input  logic                          i_clk,
    input  logic [2:0]                    i_load,
    input  logic [scpdt_pkg::RES_W-1:0]   i_res_a,
    input  logic [scpdt_pkg::RES_W-1:0]   i_res_b,
    input  scpdt_pkg::t_off_vec           i_off,
    input  scpdt_pkg::t_sub_vec           i_sub_a,
    input  scpdt_pkg::t_sub_vec           i_sub_b,
    input  logic [scpdt_pkg::MD_W-1:0]    i_max_distance,
    output scpdt_pkg::t_gap_vec           o_gap,
    output logic [scpdt_pkg::DIST_W-1:0]  o_lim,
    output scpdt_pkg::t_codes             o_codes
);
    import scpdt_pkg::*;

    logic [RES_W-1:0]  w_ra;
    logic [RES_W-1:0]  w_rb;

    logic [PROD_W-1:0] n1_r,    r1_r;
    t_prod_vec         n1_alo,  r1_alo;
    t_prod_vec         n1_ahi,  r1_ahi;
    t_prod_vec         n1_bplo, r1_bplo;
    t_prod_vec         n1_bphi, r1_bphi;
    t_off_vec          n1_off,  r1_off;
    t_codes            r1_codes;

    t_prod_vec         r2_alo;
    t_prod_vec         r2_ahi;
    t_pos_vec          n2_blo,  r2_blo;
    t_pos_vec          n2_bhi,  r2_bhi;
    logic [DIST_W-1:0] n2_lim,  r2_lim;
    t_codes            r2_codes;

    t_gap_vec          n3_gap,  r3_gap;
    logic [DIST_W-1:0] r3_lim;
    t_codes            r3_codes;

    // stage 1: clamp resolutions, sub-cell bounds in units of cell/(res_a*res_b)
    always_comb begin
        w_ra = clamp_res(i_res_a);
        w_rb = clamp_res(i_res_b);
        n1_r = {{(PROD_W-RES_W){1'b0}}, w_ra} * {{(PROD_W-RES_W){1'b0}}, w_rb};
        for (int a = 0; a < AXES; a++) begin
            n1_off[a]  = clamp_off(i_off[a]);
            n1_alo[a]  = {{(PROD_W-SUB_W){1'b0}}, i_sub_a[a]}
                       * {{(PROD_W-RES_W){1'b0}}, w_rb};
            n1_ahi[a]  = ({{(PROD_W-SUB_W){1'b0}}, i_sub_a[a]} + PROD_W'(1))
                       * {{(PROD_W-RES_W){1'b0}}, w_rb};
            n1_bplo[a] = {{(PROD_W-SUB_W){1'b0}}, i_sub_b[a]}
                       * {{(PROD_W-RES_W){1'b0}}, w_ra};
            n1_bphi[a] = ({{(PROD_W-SUB_W){1'b0}}, i_sub_b[a]} + PROD_W'(1))
                       * {{(PROD_W-RES_W){1'b0}}, w_ra};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r1_r     <= n1_r;
            r1_alo   <= n1_alo;
            r1_ahi   <= n1_ahi;
            r1_bplo  <= n1_bplo;
            r1_bphi  <= n1_bphi;
            r1_off   <= n1_off;
            r1_codes <= '{code_b: i_sub_b, code_a: i_sub_a};
        end
    end

    // stage 2: add the whole-cell offset, scale the cutoff
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n2_blo[a] = {{(POS_W-OFF_W){1'b0}}, r1_off[a]} * {{(POS_W-PROD_W){1'b0}}, r1_r}
                      + {{(POS_W-PROD_W){1'b0}}, r1_bplo[a]};
            n2_bhi[a] = {{(POS_W-OFF_W){1'b0}}, r1_off[a]} * {{(POS_W-PROD_W){1'b0}}, r1_r}
                      + {{(POS_W-PROD_W){1'b0}}, r1_bphi[a]};
        end
        n2_lim = {{(DIST_W-MD_W){1'b0}}, i_max_distance}
               * {{(DIST_W-PROD_W){1'b0}}, r1_r};
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r2_alo   <= r1_alo;
            r2_ahi   <= r1_ahi;
            r2_blo   <= n2_blo;
            r2_bhi   <= n2_bhi;
            r2_lim   <= n2_lim;
            r2_codes <= r1_codes;
        end
    end

    // stage 3: gap per axis, zero where the boxes overlap
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            if (r2_blo[a] > {{(POS_W-PROD_W){1'b0}}, r2_ahi[a]}) begin
                n3_gap[a] = GAP_W'(r2_blo[a] - {{(POS_W-PROD_W){1'b0}}, r2_ahi[a]});
            end else if ({{(POS_W-PROD_W){1'b0}}, r2_alo[a]} > r2_bhi[a]) begin
                n3_gap[a] = GAP_W'({{(POS_W-PROD_W){1'b0}}, r2_alo[a]} - r2_bhi[a]);
            end else begin
                n3_gap[a] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r3_gap   <= n3_gap;
            r3_lim   <= r2_lim;
            r3_codes <= r2_codes;
        end
    end

    assign o_gap   = r3_gap;
    assign o_lim   = r3_lim;
    assign o_codes = r3_codes;

endmodule

// ----- src/scpdt_sq.sv -----
// stages 4-7: scale by cell size, square, sum and compare with cutoff squared
`timescale 1ns / 1ps
module scpdt_sq (
    input  logic                          i_clk,
    input  logic [3:0]                    i_load,
    input  logic [scpdt_pkg::CS_W-1:0]    i_cell_edge,
    input  scpdt_pkg::t_gap_vec           i_gap,
    input  logic [scpdt_pkg::DIST_W-1:0]  i_lim,
    input  scpdt_pkg::t_codes             i_codes,
    output logic                          o_within_range,
    output scpdt_pkg::t_codes             o_codes
);
    import scpdt_pkg::*;

    t_dist_vec         n4_d,    r4_d;
    logic [DIST_W-1:0] r4_lim;
    t_codes            r4_codes;

    t_sq_vec           n5_sq,   r5_sq;
    logic [SQ_W-1:0]   n5_lim2, r5_lim2;
    t_codes            r5_codes;

    logic [SUM_W-1:0]  n6_sum,  r6_sum;
    logic [SQ_W-1:0]   r6_lim2;
    t_codes            r6_codes;

    logic              n7_within, r7_within;
    t_codes            r7_codes;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n4_d[a] = {{(DIST_W-CS_W){1'b0}}, i_cell_edge}
                    * {{(DIST_W-GAP_W){1'b0}}, i_gap[a]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load[0]) begin
            r4_d     <= n4_d;
            r4_lim   <= i_lim;
            r4_codes <= i_codes;
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n5_sq[a] = {{(SQ_W-DIST_W){1'b0}}, r4_d[a]} * {{(SQ_W-DIST_W){1'b0}}, r4_d[a]};
        end
        n5_lim2 = {{(SQ_W-DIST_W){1'b0}}, r4_lim} * {{(SQ_W-DIST_W){1'b0}}, r4_lim};
    end

    always_ff @(posedge i_clk) begin
        if (i_load[1]) begin
            r5_sq    <= n5_sq;
            r5_lim2  <= n5_lim2;
            r5_codes <= r4_codes;
        end
    end

    assign n6_sum = {{(SUM_W-SQ_W){1'b0}}, r5_sq[0]}
                  + {{(SUM_W-SQ_W){1'b0}}, r5_sq[1]}
                  + {{(SUM_W-SQ_W){1'b0}}, r5_sq[2]};

    always_ff @(posedge i_clk) begin
        if (i_load[2]) begin
            r6_sum   <= n6_sum;
            r6_lim2  <= r5_lim2;
            r6_codes <= r5_codes;
        end
    end

    assign n7_within = (r6_sum <= {{(SUM_W-SQ_W){1'b0}}, r6_lim2});

    // output register
    always_ff @(posedge i_clk) begin
        if (i_load[3]) begin
            r7_within <= n7_within;
            r7_codes  <= r6_codes;
        end
    end

    assign o_within_range = r7_within;
    assign o_codes        = r7_codes;

endmodule

// ----- src/sub_cell_pair_distance_test.sv -----
// top level of the sub-cell pair distance test
//
// one transaction on the s_axis side names a candidate pair: resolutions, the
// neighbour cell offset and both sub-cell indices. one transaction comes back on
// the m_axis side for each, in order: the verdict (least squared box distance
// at most max_distance squared) and both packed sub-cell codes.
// the test runs exactly in integers over seven register stages: bounds, offset,
// gaps, cell-size scaling, squaring, sum, compare. a new pair is taken every
// cycle while s_axis_tready is high; m_axis_tvalid rises once the pair sits in the last stage.
// each stage loads when it is empty or the stage after it moves, so a stall on
// m_axis_tready fills the bubbles first and only backs up to s_axis_tready
// once all seven stages hold a transaction. nothing is dropped or repeated.
// the cell edge and max_distance registers (byte address 0 and 4, reset 256) must
// be written through the apb port while no transaction is in flight; the block
// does not enforce it. synchronous reset empties the pipeline and restores them.
`timescale 1ns / 1ps
module sub_cell_pair_distance_test (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // res_a[4:0] res_b[9:5] cell_off_x[13:10] cell_off_y[17:14] cell_off_z[21:18]
    // sub_a_x[26:22] sub_a_y[31:27] sub_a_z[36:32]
    // sub_b_x[41:37] sub_b_y[46:42] sub_b_z[51:47], zero fill above
    input  logic [scpdt_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // within_range[0] code_a[15:1] code_b[30:16], zero fill above
    output logic [scpdt_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [scpdt_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [scpdt_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [scpdt_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import scpdt_pkg::*;

    logic [CS_W-1:0]       w_cell_edge;
    logic [MD_W-1:0]       w_max_distance;
    logic [NUM_STAGES-1:0] w_load;
    t_off_vec              w_off;
    t_sub_vec              w_sub_a;
    t_sub_vec              w_sub_b;
    t_gap_vec              w_gap;
    logic [DIST_W-1:0]     w_lim;
    t_codes                w_mid_codes;
    t_codes                w_out_codes;
    logic                  w_within;

    assign w_off   = s_axis_tdata[21:10];
    assign w_sub_a = s_axis_tdata[36:22];
    assign w_sub_b = s_axis_tdata[51:37];

    scpdt_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_cell_edge    (w_cell_edge),
        .o_max_distance (w_max_distance)
    );

    scpdt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_load    (w_load)
    );

    scpdt_gap u_gap (
        .i_clk          (i_clk),
        .i_load         (w_load[2:0]),
        .i_res_a        (s_axis_tdata[4:0]),
        .i_res_b        (s_axis_tdata[9:5]),
        .i_off          (w_off),
        .i_sub_a        (w_sub_a),
        .i_sub_b        (w_sub_b),
        .i_max_distance (w_max_distance),
        .o_gap          (w_gap),
        .o_lim          (w_lim),
        .o_codes        (w_mid_codes)
    );

    scpdt_sq u_sq (
        .i_clk          (i_clk),
        .i_load         (w_load[6:3]),
        .i_cell_edge    (w_cell_edge),
        .i_gap          (w_gap),
        .i_lim          (w_lim),
        .i_codes        (w_mid_codes),
        .o_within_range (w_within),
        .o_codes        (w_out_codes)
    );

    assign m_axis_tdata = {1'b0, w_out_codes.code_b, w_out_codes.code_a, w_within};

endmodule

// ----- tb/sv/tb_sub_cell_pair_distance_test.sv -----
// self-checking testbench for the sub-cell pair distance test
`timescale 1ns / 1ps
module tb_sub_cell_pair_distance_test;
    import scpdt_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = NUM_STAGES + 4;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_PAIRS   = 250;
    localparam int MAX_REPORTS   = 10;

    localparam logic [APB_ADDR_W-1:0] ADDR_CELL_EDGE = {REG_CELL_EDGE, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_MAX_DIST  = {REG_MAX_DIST, 2'b00};

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // shadow copy of the block's registers
    logic [CS_W-1:0] cell_edge_q = CELL_EDGE_RST;
    logic [MD_W-1:0] max_dist_q  = MAX_DIST_RST;

    logic [IN_TDATA_W-1:0]  pending_pairs[$];
    logic [OUT_TDATA_W-1:0] expected_verdicts[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic pair_taken = 1'b0;
    int  mismatch_count = 0;
    int  stall_cycles = 0;

    sub_cell_pair_distance_test u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // vectors are given as {z, y, x}
    function automatic logic [IN_TDATA_W-1:0] make_pair(input logic [RES_W-1:0] ra,
                                                        input logic [RES_W-1:0] rb,
                                                        input t_off_vec off,
                                                        input t_sub_vec sa,
                                                        input t_sub_vec sb);
        return IN_TDATA_W'({sb, sa, off, rb, ra});
    endfunction

    task automatic add_pair(input logic [IN_TDATA_W-1:0] pair);
        pending_pairs.insert(pending_pairs.size(), pair);
    endtask

    // exact box gap test with every bound scaled by res_a*res_b
    function automatic logic [OUT_TDATA_W-1:0] predict_verdict(
            input logic [IN_TDATA_W-1:0] pair,
            input logic [CS_W-1:0] cs,
            input logic [MD_W-1:0] md);
        logic [IN_TDATA_W-2*CODE_W-2*RES_W-AXES*OFF_W-1:0] fill;
        logic [RES_W-1:0]  ra;
        logic [RES_W-1:0]  rb;
        t_off_vec          off;
        t_sub_vec          sa;
        t_sub_vec          sb;
        logic [PROD_W-1:0] rr;
        logic [PROD_W-1:0] a_lo;
        logic [PROD_W-1:0] a_hi;
        logic [POS_W-1:0]  b_lo;
        logic [POS_W-1:0]  b_hi;
        logic [GAP_W-1:0]  gap;
        logic [DIST_W-1:0] scaled_gap;
        logic [DIST_W-1:0] lim;
        logic [SQ_W-1:0]   lim_sq;
        logic [SUM_W-1:0]  sum;
        logic              in_range;
        {fill, sb, sa, off, rb, ra} = pair;
        // zero resolution counts as one; 5 and 4 bits cannot exceed the limits
        if (ra == '0) ra = RES_W'(1);
        if (rb == '0) rb = RES_W'(1);
        rr  = ra * rb;
        sum = '0;
        for (int i = 0; i < AXES; i++) begin
            a_lo = sa[i] * rb;
            a_hi = (sa[i] + 1) * rb;
            b_lo = off[i] * rr + sb[i] * ra;
            b_hi = off[i] * rr + (sb[i] + 1) * ra;
            if (b_lo > a_hi) begin
                gap = b_lo - a_hi;
            end else if (a_lo > b_hi) begin
                gap = a_lo - b_hi;
            end else begin
                gap = '0;
            end
            scaled_gap = cs * gap;
            sum        = sum + scaled_gap * scaled_gap;
        end
        lim      = md * rr;
        lim_sq   = lim * lim;
        in_range = (sum <= lim_sq);
        return {1'b0, sb, sa, in_range};
    endfunction

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr[2] == REG_CELL_EDGE) begin
            cell_edge_q = data[CS_W-1:0];
        end else begin
            max_dist_q = data[MD_W-1:0];
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || s_axis_tvalid || expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // driver and receiver, both change on the falling edge
    always @(negedge i_clk) begin
        if (!s_axis_tvalid || pair_taken) begin
            if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_axis_tdata  <= pending_pairs.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: predict on each accepted pair, check each accepted result
    always @(posedge i_clk) begin
        logic [OUT_TDATA_W-1:0] want;
        pair_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_verdicts.insert(expected_verdicts.size(),
                                     predict_verdict(s_axis_tdata, cell_edge_q, max_dist_q));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected result transaction: tdata %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[0] !== want[0]
                        || m_axis_tdata[CODE_W:1] !== want[CODE_W:1]
                        || m_axis_tdata[2*CODE_W:CODE_W+1] !== want[2*CODE_W:CODE_W+1]) begin
                    if (mismatch_count < MAX_REPORTS)
                        $display({"mismatch: within_range %b/%b code_a %h/%h",
                                  " code_b %h/%h (exp/got)"},
                                 want[0], m_axis_tdata[0],
                                 want[CODE_W:1], m_axis_tdata[CODE_W:1],
                                 want[2*CODE_W:CODE_W+1], m_axis_tdata[2*CODE_W:CODE_W+1]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        logic [RES_W-1:0]      ra;
        logic [RES_W-1:0]      rb;
        t_off_vec              off;
        t_sub_vec              sa;
        t_sub_vec              sb;
        logic [63:0]           raw;
        logic [CS_W-1:0]       cs;
        logic [MD_W-1:0]       md;
        int                    mode;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pairs at the reset register values (one cell each)
        add_pair('0);
        add_pair({4'b0, {(IN_TDATA_W-4){1'b1}}});
        // boxes whose x faces touch, at full resolution
        add_pair(make_pair(5'd31, 5'd31, {4'd0, 4'd0, 4'd1},
                           {5'd30, 5'd30, 5'd30}, {5'd0, 5'd0, 5'd0}));
        // sub-cell indices at or above the resolution, far offsets
        add_pair(make_pair(5'd31, 5'd31, {4'd15, 4'd15, 4'd15},
                           {5'd31, 5'd31, 5'd31}, {5'd31, 5'd31, 5'd31}));
        add_pair(make_pair(5'd5, 5'd3, {4'd0, 4'd0, 4'd0},
                           {5'd31, 5'd7, 5'd5}, {5'd3, 5'd31, 5'd4}));
        // zero resolutions
        add_pair(make_pair(5'd0, 5'd31, {4'd1, 4'd0, 4'd0},
                           {5'd0, 5'd0, 5'd0}, {5'd31, 5'd31, 5'd31}));
        add_pair(make_pair(5'd31, 5'd0, {4'd0, 4'd1, 4'd0},
                           {5'd31, 5'd0, 5'd31}, {5'd0, 5'd0, 5'd0}));
        // gap of exactly one cell: distance equals the cutoff
        add_pair(make_pair(5'd1, 5'd1, {4'd0, 4'd0, 4'd2},
                           {5'd0, 5'd0, 5'd0}, {5'd0, 5'd0, 5'd0}));
        add_pair(make_pair(5'd1, 5'd1, {4'd2, 4'd0, 4'd0},
                           {5'd0, 5'd0, 5'd0}, {5'd0, 5'd0, 5'd0}));
        // one cell on two axes, beyond the cutoff; then one cell on x with y touching
        add_pair(make_pair(5'd1, 5'd1, {4'd0, 4'd2, 4'd2},
                           {5'd0, 5'd0, 5'd0}, {5'd0, 5'd0, 5'd0}));
        add_pair(make_pair(5'd1, 5'd1, {4'd0, 4'd1, 4'd2},
                           {5'd0, 5'd0, 5'd0}, {5'd0, 5'd0, 5'd0}));
        // neighbour box below the origin box inside the same cell
        add_pair(make_pair(5'd4, 5'd4, {4'd0, 4'd0, 4'd0},
                           {5'd3, 5'd3, 5'd3}, {5'd0, 5'd0, 5'd0}));
        add_pair(make_pair(5'd1, 5'd31, {4'd1, 4'd1, 4'd1},
                           {5'd0, 5'd0, 5'd0}, {5'd0, 5'd0, 5'd0}));
        add_pair(make_pair(5'd2, 5'd3, {4'd0, 4'd0, 4'd3},
                           {5'd0, 5'd0, 5'd1}, {5'd0, 5'd0, 5'd2}));
        add_pair(make_pair(5'd1, 5'd1, {4'd0, 4'd0, 4'd15},
                           {5'd0, 5'd0, 5'd0}, {5'd0, 5'd0, 5'd0}));
        add_pair(make_pair(5'd7, 5'd13, {4'd1, 4'd1, 4'd0},
                           {5'd6, 5'd0, 5'd6}, {5'd0, 5'd12, 5'd0}));
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin cs = 16'd1;     md = 20'd0;       end
                1: begin cs = 16'd65535; md = 20'hFFFFF;   end
                2: begin cs = 16'd0;     md = 20'($urandom); end
                3: begin cs = 16'd1000;  md = 20'd1500;    end
                4: begin
                    cs = 16'($urandom_range(1, 65535));
                    md = 20'(cs * $urandom_range(1, 3));
                end
                5: begin cs = 16'd65535; md = 20'd65535;   end
                6: begin cs = 16'd100;   md = 20'($urandom_range(0, 2000)); end
                default: begin cs = CELL_EDGE_RST; md = 20'd384; end
            endcase
            apb_write(ADDR_CELL_EDGE, APB_DATA_W'(cs));
            apb_write(ADDR_MAX_DIST, APB_DATA_W'(md));

            mode = p % 4;
            send_idle_pct  = (mode == 1) ? 85 : (mode == 3) ? 21 : 0;
            recv_stall_pct = (mode == 2) ? 85 : (mode == 3) ? 21 : 0;

            for (int k = 0; k < PHASE_PAIRS; k++) begin
                if ($urandom_range(0, 99) < 80) begin
                    // well-formed pair, mostly near neighbours
                    ra = RES_W'($urandom_range(1, MAX_RES));
                    rb = RES_W'($urandom_range(1, MAX_RES));
                    for (int i = 0; i < AXES; i++) begin
                        off[i] = ($urandom_range(0, 99) < 75) ? OFF_W'($urandom_range(0, 2))
                                                              : OFF_W'($urandom_range(0, 15));
                        sa[i]  = SUB_W'($urandom_range(0, ra - 1));
                        sb[i]  = SUB_W'($urandom_range(0, rb - 1));
                    end
                    add_pair(make_pair(ra, rb, off, sa, sb));
                end else begin
                    raw = {$urandom, $urandom};
                    add_pair({4'b0, raw[IN_TDATA_W-5:0]});
                end
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- sub_cell_pair_distance_test.f -----
src/scpdt_pkg.sv
src/scpdt_regs.sv
src/scpdt_ctrl.sv
src/scpdt_gap.sv
src/scpdt_sq.sv
src/sub_cell_pair_distance_test.sv
tb/sv/tb_sub_cell_pair_distance_test.sv
